@@ hw/rtl/ccbb_pkg.sv @@
// ----------------------------------------------------------------------------
// Character-class bitmap builder: shared package
// Byte codes, error codes, constant membership masks and the range decoder
// used by the class parser.
// ----------------------------------------------------------------------------
package ccbb_pkg;

  localparam int unsigned MapBits  = 256;
  localparam int unsigned WordBits = 64;

  // Text bytes with a meaning of their own.
  localparam logic [7:0] ChCaret  = 8'h5E;
  localparam logic [7:0] ChBslash = 8'h5C;
  localparam logic [7:0] ChDash   = 8'h2D;
  localparam logic [7:0] ChPeriod = 8'h2E;
  localparam logic [7:0] ChLowA   = 8'h61;
  localparam logic [7:0] ChLowZ   = 8'h7A;
  localparam logic [7:0] ChUpA    = 8'h41;
  localparam logic [7:0] ChUpZ    = 8'h5A;
  localparam logic [7:0] ChDig0   = 8'h30;
  localparam logic [7:0] ChDig1   = 8'h31;
  localparam logic [7:0] ChDig9   = 8'h39;
  localparam logic [7:0] ChUpE    = 8'h45;
  localparam logic [7:0] ChUpL    = 8'h4C;
  localparam logic [7:0] ChUpF    = 8'h46;
  localparam logic [7:0] ChUpW    = 8'h57;
  localparam logic [7:0] ChUpS    = 8'h53;

  // Error codes carried with every map word.
  typedef enum logic [1:0] {
    ERR_NONE   = 2'd0,
    ERR_PERIOD = 2'd1,
    ERR_RANGE  = 2'd2,
    ERR_ESCAPE = 2'd3
  } err_e;

  typedef logic [MapBits-1:0] map_t;

  // Result of a finished class, handed to the output stage.
  typedef struct packed {
    map_t map;
    err_e err;
  } frame_t;

  // Outcome of decoding an x-y range.
  typedef struct packed {
    logic ok;
    map_t mask;
  } range_t;

  // Mask of all byte values lo..hi inclusive (used for constants only).
  function automatic map_t span_mask(int unsigned lo, int unsigned hi);
    map_t m;
    for (int unsigned i = 0; i < MapBits; i++) begin
      m[i] = (i >= lo) && (i <= hi);
    end
    return m;
  endfunction

  localparam map_t MaskLower = span_mask(97, 122);
  localparam map_t MaskUpper = span_mask(65, 90);
  localparam map_t MaskDig0  = span_mask(48, 57);
  localparam map_t MaskDig1  = span_mask(49, 57);
  localparam map_t MaskNl    = span_mask(10, 10);
  localparam map_t MaskSub   = span_mask(26, 26);
  localparam map_t MaskSpace = span_mask(32, 32) | span_mask(9, 13);
  localparam map_t MaskSupp  = span_mask(33, 126) | span_mask(9, 10) | span_mask(32, 32);

  // One-hot mask of a single byte value.
  function automatic map_t byte_mask(logic [7:0] b);
    return map_t'(1) << b;
  endfunction

  // Decode a named or special range; ok is low for an unknown pair.
  function automatic range_t range_decode(logic [7:0] x, logic [7:0] y);
    range_t r;
    r.ok   = 1'b1;
    r.mask = '0;
    if (x == ChLowA && y == ChLowZ) begin
      r.mask = MaskLower;
    end else if (x == ChUpA && y == ChUpZ) begin
      r.mask = MaskUpper;
    end else if (x == ChDig0 && y == ChDig9) begin
      r.mask = MaskDig0;
    end else if (x == ChDig1 && y == ChDig9) begin
      r.mask = MaskDig1;
    end else if (x == ChUpE && y == ChUpL) begin
      r.mask = MaskNl;
    end else if (x == ChUpE && y == ChUpF) begin
      r.mask = MaskSub;
    end else if (x == ChUpW && y == ChUpS) begin
      r.mask = MaskSpace;
    end else begin
      r.ok = 1'b0;
    end
    return r;
  endfunction

endpackage

@@ hw/rtl/ccbb_class_parser.sv @@
// ----------------------------------------------------------------------------
// Character-class bitmap builder: class parser
// Holds the per-class parse state (map, lookahead byte, escape, negation,
// error) and updates it for one registered byte per cycle while take_i is
// high. On the final byte of a class it produces the finished frame.
// ----------------------------------------------------------------------------
module ccbb_class_parser
  import ccbb_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       take_i,
  input  logic [7:0] char_i,
  input  logic       last_i,
  output frame_t     frame_o
);

  map_t       map_q, map_d;
  logic [7:0] head_q, head_d;
  logic [1:0] cnt_q, cnt_d;
  logic       esc_q, esc_d;
  logic       neg_q, neg_d;
  logic       start_q, start_d;
  err_e       err_q, err_d;

  // Next-state logic for one text byte.
  always_comb begin
    map_t   add;
    range_t rng;
    logic   used;
    add     = '0;
    rng     = range_decode(head_q, char_i);
    used    = 1'b0;
    map_d   = map_q;
    head_d  = head_q;
    cnt_d   = cnt_q;
    esc_d   = esc_q;
    neg_d   = neg_q;
    err_d   = err_q;
    start_d = 1'b0;

    // The first byte of a class starts from a clean state.
    if (start_q) begin
      map_d = '0;
      cnt_d = 2'd0;
      esc_d = 1'b0;
      neg_d = 1'b0;
      err_d = ERR_NONE;
      if (char_i == ChCaret) begin
        neg_d = 1'b1;
        used  = 1'b1;
      end
    end

    if (!used) begin
      if (esc_d) begin
        add   = add | byte_mask(char_i);
        esc_d = 1'b0;
      end else if (cnt_d == 2'd1 && char_i == ChDash) begin
        cnt_d = 2'd2;
      end else if (cnt_d[1]) begin
        // Second byte after x-: apply the range.
        cnt_d = 2'd0;
        if (rng.ok) begin
          add = add | rng.mask;
        end else if (err_d == ERR_NONE) begin
          err_d = ERR_RANGE;
        end
      end else begin
        // A held byte that does not start a range is literal.
        if (cnt_d == 2'd1) begin
          add = add | byte_mask(head_q);
        end
        cnt_d = 2'd0;
        if (char_i == ChBslash) begin
          esc_d = 1'b1;
        end else if (char_i == ChPeriod) begin
          if (err_d == ERR_NONE) begin
            err_d = ERR_PERIOD;
          end
        end else begin
          head_d = char_i;
          cnt_d  = 2'd1;
        end
      end
    end

    // Close the class: flush the window and check for a dangling escape.
    if (last_i) begin
      if (cnt_d != 2'd0) begin
        add = add | byte_mask(head_d);
      end
      if (cnt_d[1]) begin
        add = add | byte_mask(ChDash);
      end
      cnt_d = 2'd0;
      if (esc_d && err_d == ERR_NONE) begin
        err_d = ERR_ESCAPE;
      end
      esc_d   = 1'b0;
      start_d = 1'b1;
    end

    map_d = map_d | add;
  end

  // Finished frame, taking negation into account.
  assign frame_o.map = neg_d ? (MaskSupp & ~map_d) : map_d;
  assign frame_o.err = err_d;

  // Parse state registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      map_q   <= '0;
      head_q  <= '0;
      cnt_q   <= 2'd0;
      esc_q   <= 1'b0;
      neg_q   <= 1'b0;
      start_q <= 1'b1;
      err_q   <= ERR_NONE;
    end else if (take_i) begin
      map_q   <= map_d;
      head_q  <= head_d;
      cnt_q   <= cnt_d;
      esc_q   <= esc_d;
      neg_q   <= neg_d;
      start_q <= start_d;
      err_q   <= err_d;
    end
  end

endmodule

@@ hw/rtl/ccbb_word_serializer.sv @@
// ----------------------------------------------------------------------------
// Character-class bitmap builder: word serializer
// Holds one finished class map and sends it as four 64-bit beats, lowest
// word first, each with the class error code.
// ----------------------------------------------------------------------------
module ccbb_word_serializer
  import ccbb_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        load_i,
  input  frame_t      frame_i,
  output logic        free_o,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [1:0]  word_index_o,
  output logic [63:0] member_bits_o,
  output logic [1:0]  error_code_o,
  output logic        last_word_o
);

  logic       vld_q;
  logic [1:0] idx_q;
  frame_t     frame_q;
  logic       fire;

  assign fire   = vld_q && !out_stall_i;
  // The buffer can take a new frame once its last word leaves.
  assign free_o = !vld_q || (fire && idx_q == 2'd3);

  // Control: valid flag and word counter.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
      idx_q <= 2'd0;
    end else if (load_i) begin
      vld_q <= 1'b1;
      idx_q <= 2'd0;
    end else if (fire) begin
      vld_q <= (idx_q != 2'd3);
      idx_q <= idx_q + 2'd1;
    end
  end

  // Frame payload.
  always_ff @(posedge clk_i) begin
    if (load_i) begin
      frame_q <= frame_i;
    end
  end

  // Output beat selection.
  assign out_valid_o   = vld_q;
  assign word_index_o  = idx_q;
  assign member_bits_o = frame_q.map[{idx_q, 6'd0} +: WordBits];
  assign error_code_o  = frame_q.err;
  assign last_word_o   = (idx_q == 2'd3);

endmodule

@@ hw/rtl/char_class_bitmap_builder.sv @@
// ----------------------------------------------------------------------------
// Character-class bitmap builder
// Parses a lexer character-class body byte by byte and sends the resulting
// 256-bit membership map as four 64-bit words with an error code.
// ----------------------------------------------------------------------------
//  Channel | Direction | Handshake            | Beat fields
//  --------+-----------+----------------------+---------------------------------
//  in      | input     | in_valid_i/in_stall_o | char_code_i, end_of_class_i
//  out     | output    | out_valid_o/out_stall_i | word_index_o, member_bits_o,
//          |           |                      | error_code_o, last_word_o
//
// An input beat is registered, then parsed; one byte per cycle is sustained
// unless a final byte waits for the buffer. A final byte yields four output
// beats through the single 64-bit output port; the frame buffer holds one
// class. The next class's bytes keep flowing while a map is sent; only another
// final byte waits for the buffer to free. Reset clears all control state.
// ----------------------------------------------------------------------------
module char_class_bitmap_builder
  import ccbb_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  char_code_i,
  input  logic        end_of_class_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [1:0]  word_index_o,
  output logic [63:0] member_bits_o,
  output logic [1:0]  error_code_o,
  output logic        last_word_o
);

  logic       in_vld_q;
  logic [7:0] in_char_q;
  logic       in_last_q;
  logic       buf_free;
  logic       take;
  frame_t     frame;

  // The held byte is parsed unless it closes a class and the buffer is busy.
  assign take       = in_vld_q && (!in_last_q || buf_free);
  assign in_stall_o = in_vld_q && !take;

  // Input register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (!in_stall_o) begin
      in_vld_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) begin
      in_char_q <= char_code_i;
      in_last_q <= end_of_class_i;
    end
  end

  ccbb_class_parser u_parser (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .take_i  (take),
    .char_i  (in_char_q),
    .last_i  (in_last_q),
    .frame_o (frame)
  );

  ccbb_word_serializer u_serializer (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .load_i        (take && in_last_q),
    .frame_i       (frame),
    .free_o        (buf_free),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .word_index_o  (word_index_o),
    .member_bits_o (member_bits_o),
    .error_code_o  (error_code_o),
    .last_word_o   (last_word_o)
  );

endmodule

@@ test/tb_top.sv @@
// ----------------------------------------------------------------------------
// Testbench for the character-class bitmap builder
// Sends class bodies one byte per beat and predicts the four map words of
// every finished class with an independent parser. Each output beat is
// checked field by field, under several sender and receiver idling mixes.
// ----------------------------------------------------------------------------
module tb_top;
  import ccbb_pkg::*;

  // Text bytes that steer the parser.
  localparam logic [7:0] CARET  = 8'h5E;
  localparam logic [7:0] BSLASH = 8'h5C;
  localparam logic [7:0] DASH   = 8'h2D;
  localparam logic [7:0] PERIOD = 8'h2E;

  localparam int unsigned CYCLE_LIMIT  = 200000;
  localparam int unsigned DRAIN_CYCLES = 20;
  localparam int unsigned MAX_REPORTS  = 10;

  // One expected map word.
  typedef struct packed {
    logic [1:0]  index;
    logic [63:0] bits;
    err_e        err;
    logic        last;
  } map_word_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  logic [7:0]  char_code_i = 8'h00;
  logic        end_of_class_i = 1'b0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic [1:0]  word_index_o;
  logic [63:0] member_bits_o;
  logic [1:0]  error_code_o;
  logic        last_word_o;

  // Parser state of the prediction.
  logic [255:0] class_map;
  logic [7:0]   range_head;
  int unsigned  window_count;
  logic         escape_open;
  logic         negated;
  logic         class_fresh;
  err_e         class_err;

  map_word_t    expected_words[$];
  logic [7:0]   pattern[$];
  logic [15:0]  range_pairs[7] = '{"az", "AZ", "09", "19", "EL", "EF", "WS"};

  int unsigned  sender_idle_pct = 0;
  int unsigned  receiver_stall_pct = 0;
  int unsigned  bytes_sent = 0;
  int unsigned  classes_sent = 0;
  int unsigned  words_checked = 0;
  int unsigned  mismatch_count = 0;
  int unsigned  cycle_count = 0;

  char_class_bitmap_builder dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .char_code_i    (char_code_i),
    .end_of_class_i (end_of_class_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .word_index_o   (word_index_o),
    .member_bits_o  (member_bits_o),
    .error_code_o   (error_code_o),
    .last_word_o    (last_word_o)
  );

  // Free-running clock, period 10.
  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  // Watchdog on the whole run.
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles with %0d words outstanding", cycle_count,
               expected_words.size());
      $display("char_class_bitmap_builder verification failed");
      $finish;
    end
  end

  // Mask of the byte values lo..hi.
  function automatic logic [255:0] byte_span(int unsigned lo, int unsigned hi);
    logic [255:0] m;
    m = '0;
    for (int unsigned i = lo; i <= hi; i++) begin
      m[i] = 1'b1;
    end
    return m;
  endfunction

  // Only the first error of a class is kept.
  function automatic void keep_first_error(err_e code);
    if (class_err == ERR_NONE) begin
      class_err = code;
    end
  endfunction

  // A byte in the leading position of a possible range.
  function automatic void take_range_head(logic [7:0] b);
    if (b == BSLASH) begin
      escape_open = 1'b1;
    end else if (b == PERIOD) begin
      keep_first_error(ERR_PERIOD);
    end else begin
      range_head   = b;
      window_count = 1;
    end
  endfunction

  // Advance the class parser by one accepted byte; a final byte queues
  // the four words of the finished map.
  function automatic void parse_class_byte(logic [7:0] b, logic last);
    logic      caret_taken;
    map_word_t w;
    caret_taken = 1'b0;
    if (class_fresh) begin
      class_map    = '0;
      window_count = 0;
      escape_open  = 1'b0;
      negated      = 1'b0;
      class_err    = ERR_NONE;
      class_fresh  = 1'b0;
      if (b == CARET) begin
        negated     = 1'b1;
        caret_taken = 1'b1;
      end
    end

    if (!caret_taken) begin
      if (escape_open) begin
        class_map[b] = 1'b1;
        escape_open  = 1'b0;
      end else if (window_count == 0) begin
        take_range_head(b);
      end else if (window_count == 1) begin
        if (b == DASH) begin
          window_count = 2;
        end else begin
          class_map[range_head] = 1'b1;
          window_count = 0;
          take_range_head(b);
        end
      end else begin
        window_count = 0;
        case ({range_head, b})
          "az":    class_map |= byte_span(97, 122);
          "AZ":    class_map |= byte_span(65, 90);
          "09":    class_map |= byte_span(48, 57);
          "19":    class_map |= byte_span(49, 57);
          "EL":    class_map[10] = 1'b1;
          "EF":    class_map[26] = 1'b1;
          "WS":    class_map |= byte_span(9, 13) | byte_span(32, 32);
          default: keep_first_error(ERR_RANGE);
        endcase
      end
    end

    if (last) begin
      // An open window at the end turns into literal bytes.
      if (window_count >= 1) begin
        class_map[range_head] = 1'b1;
      end
      if (window_count >= 2) begin
        class_map[DASH] = 1'b1;
      end
      window_count = 0;
      if (escape_open) begin
        keep_first_error(ERR_ESCAPE);
      end
      escape_open = 1'b0;
      if (negated) begin
        class_map = (byte_span(33, 126) | byte_span(9, 10) | byte_span(32, 32)) & ~class_map;
      end
      for (int k = 0; k < 4; k++) begin
        w.index = 2'(k);
        w.bits  = class_map[k*64 +: 64];
        w.err   = class_err;
        w.last  = (k == 3);
        expected_words.push_back(w);
      end
      class_fresh = 1'b1;
    end
  endfunction

  // Count a failure; only the first few are printed.
  function automatic void note_failure(string msg);
    mismatch_count++;
    if (mismatch_count <= MAX_REPORTS) begin
      $display("MISMATCH at cycle %0d: %s", cycle_count, msg);
    end
  endfunction

  // Send one byte as an input beat, with random idle cycles ahead of it.
  task automatic send_byte(logic [7:0] b, logic last);
    while ($urandom_range(0, 99) < sender_idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i     <= 1'b1;
    char_code_i    <= b;
    end_of_class_i <= last;
    @(posedge clk_i);
    while (in_stall_o) begin
      @(posedge clk_i);
    end
    parse_class_byte(b, last);
    bytes_sent++;
    @(negedge clk_i);
  endtask

  // Send the bytes held in pattern as one class.
  task automatic send_pattern();
    for (int i = 0; i < pattern.size(); i++) begin
      send_byte(pattern[i], i == pattern.size() - 1);
    end
    classes_sent++;
  endtask

  // Receiver stalls at the rate of the current phase.
  always @(negedge clk_i) begin
    out_stall_i <= ($urandom_range(0, 99) < receiver_stall_pct);
  end

  // Compare every output beat with the oldest expected word.
  always @(posedge clk_i) begin : check_words
    map_word_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (expected_words.size() == 0) begin
        note_failure($sformatf("unexpected word index %0d bits %h err %0d last %0b",
                               word_index_o, member_bits_o, error_code_o, last_word_o));
      end else begin
        want = expected_words.pop_front();
        words_checked++;
        if (word_index_o !== want.index || member_bits_o !== want.bits ||
            error_code_o !== want.err || last_word_o !== want.last) begin
          note_failure($sformatf({"expected index %0d bits %h err %0d last %0b, ",
                                  "got index %0d bits %h err %0d last %0b"},
                                 want.index, want.bits, want.err, want.last,
                                 word_index_o, member_bits_o, error_code_o, last_word_o));
        end
      end
    end
  end

  // Named and special ranges, extreme byte values and an escaped period.
  task automatic test_ranges();
    pattern = '{"a", DASH, "z", "E", DASH, "L", "E", DASH, "F"};
    send_pattern();
    pattern = '{8'h00, CARET, BSLASH, PERIOD, 8'hFF};
    send_pattern();
  endtask

  // A leading caret alone, and with a range and a bad range ending in a period.
  task automatic test_negation();
    pattern = '{CARET};
    send_pattern();
    pattern = '{CARET, "W", DASH, "S", "a", DASH, PERIOD};
    send_pattern();
  endtask

  // Several errors in one class, a dangling backslash and a trailing x-.
  task automatic test_errors();
    pattern = '{PERIOD, "q", DASH, "r", BSLASH};
    send_pattern();
    pattern = '{"x", DASH};
    send_pattern();
  endtask

  // Mostly well-formed classes with random content, some broken or noise.
  task automatic test_random_classes(int unsigned idle_pct, int unsigned stall_pct,
                                     int unsigned n_bytes);
    int unsigned first_byte;
    logic [15:0] pair;
    sender_idle_pct    = idle_pct;
    receiver_stall_pct = stall_pct;
    first_byte         = bytes_sent;
    while (bytes_sent - first_byte < n_bytes) begin
      pattern.delete();
      if ($urandom_range(0, 9) == 0) begin
        repeat ($urandom_range(1, 6)) pattern.push_back(8'($urandom));
      end else begin
        if ($urandom_range(0, 99) < 20) begin
          pattern.push_back(CARET);
        end
        repeat ($urandom_range(0, 5)) begin
          case ($urandom_range(0, 9))
            0, 1, 2: begin
              pattern.push_back(8'($urandom_range(32, 126)));
            end
            3, 4, 5: begin
              pair = range_pairs[$urandom_range(0, 6)];
              pattern.push_back(pair[15:8]);
              pattern.push_back(DASH);
              pattern.push_back(pair[7:0]);
            end
            6, 7: begin
              pattern.push_back(BSLASH);
              pattern.push_back(8'($urandom));
            end
            8: begin
              pattern.push_back(8'($urandom));
            end
            default: begin
              // Broken piece: a period, a bad range or an open x- window.
              case ($urandom_range(0, 2))
                0: pattern.push_back(PERIOD);
                1: begin
                  pattern.push_back(8'($urandom));
                  pattern.push_back(DASH);
                  pattern.push_back(8'($urandom));
                end
                default: begin
                  pattern.push_back(8'($urandom_range(32, 126)));
                  pattern.push_back(DASH);
                end
              endcase
            end
          endcase
        end
        if ($urandom_range(0, 99) < 6) begin
          pattern.push_back(BSLASH);
        end
        if (pattern.size() == 0) begin
          pattern.push_back(8'($urandom));
        end
      end
      send_pattern();
    end
  endtask

  initial begin
    class_map    = '0;
    range_head   = 8'h00;
    window_count = 0;
    escape_open  = 1'b0;
    negated      = 1'b0;
    class_fresh  = 1'b1;
    class_err    = ERR_NONE;

    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    test_ranges();
    test_negation();
    test_errors();
    test_random_classes(0, 0, 80);
    test_random_classes(80, 0, 80);
    test_random_classes(0, 80, 80);
    test_random_classes(22, 22, 80);
    in_valid_i <= 1'b0;

    // Let the last maps drain, then a few quiet cycles.
    while (expected_words.size() != 0) begin
      @(posedge clk_i);
    end
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("Sent %0d classes in %0d bytes; checked %0d map words, %0d failures.",
             classes_sent, bytes_sent, words_checked, mismatch_count);
    $display("Phases: no idling, sender idle 80%%, receiver stall 80%%, both 22%%.");
    if (mismatch_count == 0) begin
      $display("char_class_bitmap_builder verification clean");
    end else begin
      $display("char_class_bitmap_builder verification failed");
    end
    $finish;
  end

endmodule
